// ----- hw/rtl/pslm_pkg.sv -----
// Package for the pooled sorted list manager: sizes, operation and status codes,
// and the sequencer state type. No dependencies.
package pslm_pkg;
  localparam int MAX_SLOTS  = 256;
  localparam int LIST_COUNT = 8;
  localparam int HW = 9;   // handle width
  localparam int AW = 8;   // slot address width
  localparam int LW = 3;   // list number width

  localparam logic [2:0] FN_ADD_SORTED = 3'd0;
  localparam logic [2:0] FN_ADD_HEAD   = 3'd1;
  localparam logic [2:0] FN_REMOVE     = 3'd2;
  localparam logic [2:0] FN_ADD_AFTER  = 3'd3;
  localparam logic [2:0] FN_ADD_BEFORE = 3'd4;
  localparam logic [2:0] FN_MOVE       = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LIST  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NO_TARGET = 3'd3;
  localparam logic [2:0] ST_NO_REF    = 3'd4;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN, S_SCAN_WAIT, S_RD_REF, S_RD_REF_WAIT,
    S_LINK_REF, S_RD_TGT, S_RD_TGT_WAIT, S_UNLINK, S_INS, S_RD_CUR, S_RD_CUR_WAIT,
    S_RD_NX, S_RD_NX_WAIT, S_WALK, S_FIN, S_OUT
  } state_t;
endpackage

// ----- hw/rtl/pslm_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module pslm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- hw/rtl/pooled_sorted_list_manager_core.sv -----
// Top level of the pooled sorted list manager.
// Depends on pslm_pkg and pslm_ram.
//
// Usage: a request enters on the in_ channel (valid/ready) and names one
// operation: add sorted, add at head, remove, add after or before a live
// reference slot, or move sorted. Each accepted request gives exactly one
// result on the out_ channel (status and slot handle), except func codes 6
// and 7, which change nothing and produce no result. The user must write
// slots_in_use with cfg_we only while the block is idle; the block does not
// enforce it. Slot records live in one RAM with a single port, worked by a
// sequencer. Work grows with each slot visited by the free scan (the free
// slot included) and each list element passed by the sorted walk; both run
// at most MAX_SLOTS steps. A request rejected by a handle check goes from
// S_DISPATCH straight to S_OUT.
// After reset, a clearing pass zeroes every slot of the slot RAM;
// in_ready stays low meanwhile. The result waits in an output register;
// while the receiver stalls the block holds it and takes no new request.
// in_ready rises in the cycle after the result is taken.
module pooled_sorted_list_manager_core
  import pslm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_func,
  input  logic [31:0]   in_user_word,
  input  logic [2:0]    in_list_number,
  input  logic [31:0]   in_order_key,
  input  logic [8:0]    in_target_handle,
  input  logic [8:0]    in_ref_handle,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [8:0]    out_slot_handle
);
  // Slot record packed into one RAM word: live, list, key, next, prev.
  // The user word sits in its own RAM, written only on claim.
  typedef struct packed {
    logic          live;
    logic [LW-1:0] lst;
    logic [31:0]   key;
    logic [HW-1:0] nxt;
    logic [HW-1:0] prv;
  } rec_t;
  localparam int RW = $bits(rec_t);

  state_t state_r, state_nxt;
  logic [8:0]    cap_r;
  logic [HW-1:0] head_r [LIST_COUNT];
  logic [HW-1:0] tail_r [LIST_COUNT];

  // request
  logic [2:0]  fn_r;
  logic [31:0] user_r, key_r;
  logic [LW-1:0] lst_r;
  logic [HW-1:0] tgt_r, ref_r;
  // work
  logic [HW-1:0] h_r, cur_r, nx_r, nxt_h_r, prv_h_r;
  logic [HW-1:0] scan_r;
  logic [HW-1:0] steps_r;
  logic [LW-1:0] rl_r;
  logic [1:0]    phase_r;
  rec_t          rrec_r;
  logic [2:0]    st_r;
  logic [HW-1:0] oh_r;
  logic          ov_r;

  logic          we;
  logic [AW-1:0] addr;
  rec_t          wrec, rrec;
  logic          uwe;
  logic [31:0]   urd;

  pslm_ram #(.WIDTH(RW), .DEPTH(MAX_SLOTS)) u_rec (
    .clk(clk), .we(we), .addr(addr), .wdata(wrec), .rdata(rrec));
  pslm_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_user (
    .clk(clk), .we(uwe), .addr(addr), .wdata(user_r), .rdata(urd));

  logic [HW-1:0] ecap;
  assign ecap = (cap_r > 9'(MAX_SLOTS)) ? HW'(MAX_SLOTS) : cap_r;

  function automatic logic vh(input logic [HW-1:0] h, input logic [HW-1:0] c);
    return (h != '0) && (h <= c);
  endfunction

  function automatic logic [AW-1:0] ix(input logic [HW-1:0] h);
    logic [HW-1:0] t;
    t = h - HW'(1);
    return t[AW-1:0];
  endfunction

  // A new request is taken only when idle and no result is waiting, so the
  // result registers stay steady while the receiver stalls.
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_slot_handle = oh_r;

  // Sequencer. phase_r sequences multi-write steps through the one port.
  // Next state and RAM control are decoded combinationally from state and
  // phase below; the registers are written in one sequential block.
  logic ins_end, ins_lt;
  assign ins_end = !vh(nx_r, ecap) || (steps_r >= HW'(MAX_SLOTS));
  assign ins_lt  = key_r < rrec_r.key;

  always_comb begin
    we = 1'b0; uwe = 1'b0; addr = ix(h_r); wrec = rrec_r;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1; addr = scan_r[AW-1:0]; wrec = '0;
        if (scan_r == HW'(MAX_SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid && in_ready) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        addr = '0;
        case (fn_r)
          FN_ADD_SORTED, FN_ADD_HEAD:
            state_nxt = (32'(lst_r) >= 32'(LIST_COUNT)) ? S_OUT : S_SCAN;
          FN_ADD_AFTER, FN_ADD_BEFORE:
            state_nxt = vh(ref_r, ecap) ? S_RD_REF : S_OUT;
          FN_REMOVE, FN_MOVE:
            state_nxt = vh(tgt_r, ecap) ? S_RD_TGT : S_OUT;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        addr = scan_r[AW-1:0];
        state_nxt = (scan_r >= ecap) ? S_OUT : S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        addr = scan_r[AW-1:0];
        state_nxt = S_SCAN;
        if (!rrec.live) state_nxt = (fn_r == FN_ADD_AFTER || fn_r == FN_ADD_BEFORE)
                                    ? S_LINK_REF : S_INS;
      end
      S_RD_REF: begin addr = ix(ref_r); state_nxt = S_RD_REF_WAIT; end
      S_RD_REF_WAIT: begin
        addr = ix(ref_r);
        state_nxt = rrec.live ? S_SCAN : S_OUT;
      end
      S_LINK_REF: begin
        // phase 0: write new slot, 1: update ref, 2: read neighbor, 3: patch it
        case (phase_r)
          2'd0: begin
            we = 1'b1; uwe = 1'b1; addr = ix(h_r);
            wrec.live = 1'b1; wrec.lst = rrec_r.lst; wrec.key = rrec_r.key;
            if (fn_r == FN_ADD_AFTER) begin
              wrec.prv = ref_r; wrec.nxt = rrec_r.nxt;
            end else begin
              wrec.prv = rrec_r.prv; wrec.nxt = ref_r;
            end
          end
          2'd1: begin
            we = 1'b1; addr = ix(ref_r); wrec = rrec_r;
            if (fn_r == FN_ADD_AFTER) wrec.nxt = h_r; else wrec.prv = h_r;
          end
          2'd2: addr = ix(nx_r);
          default: begin
            addr = ix(nx_r); wrec = rrec;
            we = vh(nx_r, ecap);
            if (fn_r == FN_ADD_AFTER) wrec.prv = h_r; else wrec.nxt = h_r;
          end
        endcase
        if (phase_r == 2'd3) state_nxt = S_OUT;
      end
      S_RD_TGT: begin addr = ix(tgt_r); state_nxt = S_RD_TGT_WAIT; end
      S_RD_TGT_WAIT: begin
        addr = ix(tgt_r);
        if (!rrec.live) state_nxt = S_OUT;
        else if (fn_r == FN_MOVE && 32'(lst_r) >= 32'(LIST_COUNT)) state_nxt = S_OUT;
        else state_nxt = S_UNLINK;
      end
      S_UNLINK: begin
        // phases: 0 read prev, 1 patch prev.next, 2 read next, 3 patch next.prev
        case (phase_r)
          2'd0: addr = ix(prv_h_r);
          2'd1: begin
            addr = ix(prv_h_r); wrec = rrec; wrec.nxt = nxt_h_r;
            we = vh(prv_h_r, ecap);
          end
          2'd2: addr = ix(nxt_h_r);
          default: begin
            addr = ix(nxt_h_r); wrec = rrec; wrec.prv = prv_h_r;
            we = vh(nxt_h_r, ecap);
          end
        endcase
        if (phase_r == 2'd3) state_nxt = (fn_r == FN_MOVE) ? S_INS : S_FIN;
      end
      S_INS: begin
        addr = ix(cur_r);
        if (!vh(cur_r, ecap) || fn_r == FN_ADD_HEAD) state_nxt = S_FIN;
        else state_nxt = S_RD_CUR_WAIT;
      end
      S_RD_CUR_WAIT: begin
        addr = ix(cur_r);
        state_nxt = (key_r < rrec.key) ? S_FIN : S_RD_NX;
      end
      S_RD_NX: begin
        addr = ix(nx_r);
        state_nxt = ins_end ? S_FIN : S_RD_NX_WAIT;
      end
      S_RD_NX_WAIT: begin
        addr = ix(nx_r);
        state_nxt = S_WALK;
      end
      S_WALK: begin
        addr = ix(nx_r);
        state_nxt = ins_lt ? S_FIN : S_RD_NX;
      end
      S_FIN: begin
        // phase 0: write own record, 1: read neighbor, 2: patch neighbor,
        // 3: read second neighbor, which S_RD_CUR then patches
        case (phase_r)
          2'd0: begin
            we = (fn_r != FN_REMOVE); uwe = (fn_r != FN_MOVE) && (fn_r != FN_REMOVE);
            addr = ix(h_r);
            wrec.live = 1'b1; wrec.lst = rl_r; wrec.key = key_r;
            wrec.prv = prv_h_r; wrec.nxt = nxt_h_r;
            if (fn_r == FN_REMOVE) begin
              we = 1'b1; wrec = rrec_r; wrec.live = 1'b0; wrec.nxt = '0; wrec.prv = '0;
            end
          end
          2'd1: addr = ix(prv_h_r);
          2'd2: begin
            addr = ix(prv_h_r); wrec = rrec; wrec.nxt = h_r;
            we = (fn_r != FN_REMOVE) && vh(prv_h_r, ecap);
          end
          default: begin
            addr = ix(nxt_h_r);
          end
        endcase
        if (phase_r == 2'd3) state_nxt = S_RD_CUR;
      end
      S_RD_CUR: begin
        // final patch: next.prev = h
        addr = ix(nxt_h_r); wrec = rrec; wrec.prv = h_r;
        we = (fn_r != FN_REMOVE) && vh(nxt_h_r, ecap);
        state_nxt = S_OUT;
      end
      S_OUT: if (!ov_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cap_r   <= 9'd256;
      scan_r  <= '0;
      phase_r <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < LIST_COUNT; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (ov_r && out_ready) ov_r <= 1'b0;
      state_r <= state_nxt;
      case (state_r)
        S_CLEAR: scan_r <= scan_r + 1'b1;
        S_IDLE: if (in_valid && in_ready) begin
          fn_r <= in_func; user_r <= in_user_word; lst_r <= in_list_number;
          key_r <= in_order_key; tgt_r <= in_target_handle; ref_r <= in_ref_handle;
          scan_r <= '0; phase_r <= '0; steps_r <= '0;
          st_r <= ST_OK; oh_r <= '0;
        end
        S_DISPATCH: begin
          if (fn_r == FN_ADD_AFTER || fn_r == FN_ADD_BEFORE) begin
            if (!vh(ref_r, ecap)) st_r <= ST_NO_REF;
          end else if (fn_r == FN_REMOVE || fn_r == FN_MOVE) begin
            if (!vh(tgt_r, ecap)) st_r <= ST_NO_TARGET;
            h_r <= tgt_r;
          end
          rl_r <= lst_r;
          cur_r <= head_r[lst_r];
        end
        S_SCAN: if (scan_r >= ecap) st_r <= ST_FULL;
        S_SCAN_WAIT: begin
          if (!rrec.live) begin
            h_r <= scan_r + 1'b1;
            phase_r <= '0;
          end else scan_r <= scan_r + 1'b1;
        end
        S_RD_REF_WAIT: begin
          rrec_r <= rrec;
          if (!rrec.live) st_r <= ST_NO_REF;
          nx_r <= (fn_r == FN_ADD_AFTER) ? rrec.nxt : rrec.prv;
        end
        S_LINK_REF: begin
          phase_r <= phase_r + 1'b1;
          if (phase_r == 2'd0 && !vh(nx_r, ecap)) begin
            if (fn_r == FN_ADD_AFTER) tail_r[rrec_r.lst] <= h_r;
            else head_r[rrec_r.lst] <= h_r;
          end
          if (phase_r == 2'd3) oh_r <= h_r;
        end
        S_RD_TGT_WAIT: begin
          rrec_r <= rrec;
          prv_h_r <= rrec.prv; nxt_h_r <= rrec.nxt;
          phase_r <= '0;
          if (!rrec.live) st_r <= ST_NO_TARGET;
          else if (fn_r == FN_MOVE && 32'(lst_r) >= 32'(LIST_COUNT)) st_r <= ST_BAD_LIST;
        end
        S_UNLINK: begin
          phase_r <= phase_r + 1'b1;
          if (phase_r == 2'd0) begin
            if (!vh(prv_h_r, ecap)) head_r[rrec_r.lst] <= nxt_h_r;
            if (!vh(nxt_h_r, ecap)) tail_r[rrec_r.lst] <= prv_h_r;
          end
          if (phase_r == 2'd3) begin
            // head may have changed if the moved slot was at the head
            cur_r <= (!vh(prv_h_r, ecap) && rrec_r.lst == lst_r) ? nxt_h_r : head_r[lst_r];
          end
        end
        S_INS: begin
          phase_r <= '0;
          if (fn_r == FN_ADD_HEAD) begin
            // The old head is kept as the next link even when it names no slot.
            prv_h_r <= '0; nxt_h_r <= cur_r; head_r[rl_r] <= h_r;
            if (!vh(cur_r, ecap)) tail_r[rl_r] <= h_r;
          end else if (!vh(cur_r, ecap)) begin
            prv_h_r <= '0; nxt_h_r <= '0;
            head_r[rl_r] <= h_r; tail_r[rl_r] <= h_r;
          end
        end
        S_RD_CUR_WAIT: begin
          if (key_r < rrec.key) begin
            prv_h_r <= '0; nxt_h_r <= cur_r; head_r[rl_r] <= h_r;
          end else nx_r <= rrec.nxt;
        end
        S_RD_NX: if (ins_end) begin
          prv_h_r <= cur_r; nxt_h_r <= '0; tail_r[rl_r] <= h_r;
        end
        S_RD_NX_WAIT: rrec_r <= rrec;
        S_WALK: begin
          if (ins_lt) begin
            prv_h_r <= cur_r; nxt_h_r <= nx_r;
          end else begin
            cur_r <= nx_r; nx_r <= rrec_r.nxt; steps_r <= steps_r + 1'b1;
          end
        end
        S_FIN: begin
          phase_r <= phase_r + 1'b1;
          if (phase_r == 2'd3) oh_r <= h_r;
        end
        S_OUT: if (!ov_r) begin
          ov_r <= 1'b1;
          if (st_r != ST_OK) oh_r <= '0;
          else if (fn_r == FN_REMOVE || fn_r == FN_MOVE) oh_r <= h_r;
        end
        default: ;
      endcase
      // list number check for add
      if (state_r == S_DISPATCH && (fn_r == FN_ADD_SORTED || fn_r == FN_ADD_HEAD)
          && 32'(lst_r) >= 32'(LIST_COUNT)) st_r <= ST_BAD_LIST;
    end
  end

  // The user word is stored per slot, but no result reads it back.
  logic unused_urd;
  assign unused_urd = ^urd;
endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for pooled_sorted_list_manager_core: a queue-fed request driver,
// a result monitor and a predictor of the slot pool. Depends on pslm_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import pslm_pkg::*;

  // Codes that the block must ignore: they change nothing and give no result.
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;
  // Cycles allowed after the last result before a register write or the end.
  localparam int SETTLE_CYCLES = 1600;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] user_word;
    logic [2:0]  list_number;
    logic [31:0] order_key;
    logic [8:0]  target_handle;
    logic [8:0]  ref_handle;
  } pool_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] slot_handle;
  } pool_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_func = '0;
  logic [31:0] in_user_word = '0;
  logic [2:0]  in_list_number = '0;
  logic [31:0] in_order_key = '0;
  logic [8:0]  in_target_handle = '0;
  logic [8:0]  in_ref_handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [8:0]  out_slot_handle;

  pooled_sorted_list_manager_core u_top (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid, .in_ready, .in_func, .in_user_word, .in_list_number,
    .in_order_key, .in_target_handle, .in_ref_handle,
    .out_valid, .out_ready, .out_status, .out_slot_handle
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the pool, kept in step with every accepted request.
  logic [8:0]  pool_cap;
  logic        pool_live [MAX_SLOTS];
  logic [8:0]  pool_next [MAX_SLOTS];
  logic [8:0]  pool_prev [MAX_SLOTS];
  logic [2:0]  pool_list [MAX_SLOTS];
  logic [31:0] pool_key  [MAX_SLOTS];
  logic [31:0] pool_user [MAX_SLOTS];
  logic [8:0]  pool_head [LIST_COUNT];
  logic [8:0]  pool_tail [LIST_COUNT];

  pool_req_t pending_reqs[$];
  pool_rsp_t expected_rsps[$];
  int        error_count = 0;
  int        reqs_sent = 0;
  int        rsps_seen = 0;
  bit        no_idle = 1'b0;

  function automatic int usable_slots();
    return (pool_cap > MAX_SLOTS) ? MAX_SLOTS : int'(pool_cap);
  endfunction

  // A handle names a slot only when it falls inside the usable capacity.
  function automatic bit handle_ok(logic [8:0] h);
    return (h >= 1) && (int'(h) <= usable_slots());
  endfunction

  function automatic bit handle_live(logic [8:0] h);
    return handle_ok(h) && pool_live[h - 1];
  endfunction

  function automatic logic [8:0] first_free();
    for (int i = 0; i < usable_slots(); i++)
      if (!pool_live[i]) return 9'(i + 1);
    return '0;
  endfunction

  function automatic void detach(logic [8:0] h);
    logic [8:0] nx, pv;
    logic [2:0] lst;
    lst = pool_list[h - 1];
    nx = pool_next[h - 1];
    pv = pool_prev[h - 1];
    if (handle_ok(pv)) pool_next[pv - 1] = nx;
    else pool_head[lst] = nx;
    if (handle_ok(nx)) pool_prev[nx - 1] = pv;
    else pool_tail[lst] = pv;
    pool_next[h - 1] = '0;
    pool_prev[h - 1] = '0;
  endfunction

  // Ascending insertion; an equal key lands after the keys already there.
  // The walk gives up after MAX_SLOTS steps and treats that slot as the end.
  function automatic void link_sorted(logic [8:0] h, logic [2:0] lst, logic [31:0] key);
    logic [8:0] cur, nx;
    bit at_end;
    cur = pool_head[lst];
    pool_list[h - 1] = lst;
    pool_key[h - 1] = key;
    pool_next[h - 1] = '0;
    pool_prev[h - 1] = '0;
    if (!handle_ok(cur)) begin
      pool_head[lst] = h;
      pool_tail[lst] = h;
      return;
    end
    if (key < pool_key[cur - 1]) begin
      pool_next[h - 1] = cur;
      pool_prev[cur - 1] = h;
      pool_head[lst] = h;
      return;
    end
    for (int steps = 0; ; steps++) begin
      nx = pool_next[cur - 1];
      at_end = !handle_ok(nx) || steps >= MAX_SLOTS;
      if (at_end || key < pool_key[nx - 1]) begin
        pool_prev[h - 1] = cur;
        pool_next[h - 1] = at_end ? 9'd0 : nx;
        pool_next[cur - 1] = h;
        if (!at_end) pool_prev[nx - 1] = h;
        else pool_tail[lst] = h;
        return;
      end
      cur = nx;
    end
  endfunction

  function automatic void link_head(logic [8:0] h, logic [2:0] lst, logic [31:0] key);
    logic [8:0] old;
    old = pool_head[lst];
    pool_list[h - 1] = lst;
    pool_key[h - 1] = key;
    pool_prev[h - 1] = '0;
    pool_next[h - 1] = old;
    pool_head[lst] = h;
    if (handle_ok(old)) pool_prev[old - 1] = h;
    else pool_tail[lst] = h;
  endfunction

  // Applies one request to the shadow pool and queues the result it should give.
  function automatic void apply_request(pool_req_t rq);
    pool_rsp_t rsp;
    logic [8:0] h, nb, rf;
    logic [2:0] lst;
    rsp = '{status: ST_OK, slot_handle: '0};
    rf = rq.ref_handle;
    case (rq.func)
      FN_ADD_SORTED, FN_ADD_HEAD: begin
        // The list number is three bits wide, so it can never be out of range here.
        h = first_free();
        if (h == 0) rsp.status = ST_FULL;
        else begin
          pool_live[h - 1] = 1'b1;
          pool_user[h - 1] = rq.user_word;
          if (rq.func == FN_ADD_SORTED) link_sorted(h, rq.list_number, rq.order_key);
          else link_head(h, rq.list_number, rq.order_key);
          rsp.slot_handle = h;
        end
      end
      FN_REMOVE: begin
        if (!handle_live(rq.target_handle)) rsp.status = ST_NO_TARGET;
        else begin
          detach(rq.target_handle);
          pool_live[rq.target_handle - 1] = 1'b0;
          rsp.slot_handle = rq.target_handle;
        end
      end
      FN_ADD_AFTER, FN_ADD_BEFORE: begin
        if (!handle_live(rf)) rsp.status = ST_NO_REF;
        else begin
          h = first_free();
          if (h == 0) rsp.status = ST_FULL;
          else begin
            pool_live[h - 1] = 1'b1;
            pool_user[h - 1] = rq.user_word;
            lst = pool_list[rf - 1];
            pool_list[h - 1] = lst;
            pool_key[h - 1] = pool_key[rf - 1];
            if (rq.func == FN_ADD_AFTER) begin
              nb = pool_next[rf - 1];
              pool_prev[h - 1] = rf;
              pool_next[h - 1] = nb;
              pool_next[rf - 1] = h;
              if (handle_ok(nb)) pool_prev[nb - 1] = h;
              else pool_tail[lst] = h;
            end else begin
              nb = pool_prev[rf - 1];
              pool_prev[h - 1] = nb;
              pool_next[h - 1] = rf;
              pool_prev[rf - 1] = h;
              if (handle_ok(nb)) pool_next[nb - 1] = h;
              else pool_head[lst] = h;
            end
            rsp.slot_handle = h;
          end
        end
      end
      FN_MOVE: begin
        if (!handle_live(rq.target_handle)) rsp.status = ST_NO_TARGET;
        else begin
          detach(rq.target_handle);
          link_sorted(rq.target_handle, rq.list_number, rq.order_key);
          rsp.slot_handle = rq.target_handle;
        end
      end
      default: return;
    endcase
    expected_rsps.push_back(rsp);
  endfunction

  function automatic int gap_length();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(8, 60);
  endfunction

  // Driver: offers queued requests, holding each one steady until it is taken.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_request('{in_func, in_user_word, in_list_number, in_order_key,
                        in_target_handle, in_ref_handle});
        reqs_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          pool_req_t rq;
          rq = pending_reqs.pop_front();
          in_func <= rq.func;
          in_user_word <= rq.user_word;
          in_list_number <= rq.list_number;
          in_order_key <= rq.order_key;
          in_target_handle <= rq.target_handle;
          in_ref_handle <= rq.ref_handle;
          in_valid <= 1'b1;
          send_gap <= gap_length();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result channel at random and checks every result taken.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        rsps_seen++;
        if (expected_rsps.size() == 0) begin
          $error("unexpected result: status %0d handle %0d", out_status, out_slot_handle);
          error_count++;
        end else begin
          pool_rsp_t want;
          want = expected_rsps.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            error_count++;
          end
          if (out_slot_handle !== want.slot_handle) begin
            $error("slot_handle: expected %0d, got %0d", want.slot_handle, out_slot_handle);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left <= gap_length();
      end
    end
  end

  function automatic pool_req_t mk_req(logic [2:0] fn, logic [31:0] user, logic [2:0] lst,
                                       logic [31:0] key, logic [8:0] tgt, logic [8:0] rf);
    return '{fn, user, lst, key, tgt, rf};
  endfunction

  // Handles mostly land on usable slots so that operations find live targets.
  function automatic logic [8:0] pick_handle();
    int top;
    top = (usable_slots() < 1) ? 1 : usable_slots();
    if ($urandom_range(0, 99) < 85) return 9'($urandom_range(1, top));
    return 9'($urandom_range(0, 511));
  endfunction

  function automatic pool_req_t random_req();
    int pick;
    logic [2:0] fn;
    logic [31:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 30) fn = FN_ADD_SORTED;
    else if (pick < 40) fn = FN_ADD_HEAD;
    else if (pick < 64) fn = FN_REMOVE;
    else if (pick < 75) fn = FN_ADD_AFTER;
    else if (pick < 86) fn = FN_ADD_BEFORE;
    else if (pick < 97) fn = FN_MOVE;
    else fn = pick[0] ? FN_SPARE_A : FN_SPARE_B;
    // Small keys produce many ties; full-range keys exercise every bit.
    key = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
    return mk_req(fn, $urandom, 3'($urandom_range(0, 7)), key, pick_handle(), pick_handle());
  endfunction

  // Waits until all requests are taken and answered, then lets a late request settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [8:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    pool_cap = value;
    cfg_we <= 1'b0;
  endtask

  logic [8:0] cap_plan [10] = '{9'd16, 9'd1, 9'd0, 9'd40, 9'd3, 9'd511, 9'd256, 9'd200,
                                9'd2, 9'd8};

  initial begin
    pool_cap = 9'd256;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      pool_live[i] = 1'b0;
      pool_next[i] = '0;
      pool_prev[i] = '0;
      pool_list[i] = '0;
      pool_key[i] = '0;
      pool_user[i] = '0;
    end
    for (int i = 0; i < LIST_COUNT; i++) begin
      pool_head[i] = '0;
      pool_tail[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset capacity: ties, head insertion, neighbors, bad handles.
    pending_reqs.push_back(mk_req(FN_ADD_SORTED, 32'h0, 3'd0, 32'd5, 9'd0, 9'd0));
    pending_reqs.push_back(mk_req(FN_ADD_SORTED, 32'hFFFF_FFFF, 3'd0, 32'd5, 9'd0, 9'd0));
    pending_reqs.push_back(mk_req(FN_ADD_HEAD, 32'h1234_5678, 3'd0, 32'd9, 9'd0, 9'd0));
    pending_reqs.push_back(mk_req(FN_ADD_SORTED, 32'h1, 3'd0, 32'd0, 9'd0, 9'd0));
    pending_reqs.push_back(mk_req(FN_ADD_SORTED, 32'h2, 3'd7, 32'hFFFF_FFFF, 9'd0, 9'd0));
    pending_reqs.push_back(mk_req(FN_ADD_AFTER, 32'h3, 3'd0, 32'd0, 9'd0, 9'd1));
    pending_reqs.push_back(mk_req(FN_ADD_BEFORE, 32'h4, 3'd0, 32'd0, 9'd0, 9'd4));
    pending_reqs.push_back(mk_req(FN_ADD_AFTER, 32'h5, 3'd0, 32'd0, 9'd0, 9'd0));
    pending_reqs.push_back(mk_req(FN_ADD_BEFORE, 32'h6, 3'd0, 32'd0, 9'd0, 9'd511));
    pending_reqs.push_back(mk_req(FN_ADD_AFTER, 32'h7, 3'd0, 32'd0, 9'd0, 9'd5));
    pending_reqs.push_back(mk_req(FN_REMOVE, 32'h0, 3'd0, 32'd0, 9'd0, 9'd0));
    pending_reqs.push_back(mk_req(FN_REMOVE, 32'h0, 3'd0, 32'd0, 9'd257, 9'd0));
    pending_reqs.push_back(mk_req(FN_REMOVE, 32'h0, 3'd0, 32'd0, 9'd2, 9'd0));
    pending_reqs.push_back(mk_req(FN_REMOVE, 32'h0, 3'd0, 32'd0, 9'd2, 9'd0));
    pending_reqs.push_back(mk_req(FN_MOVE, 32'h0, 3'd7, 32'hFFFF_FFFF, 9'd1, 9'd0));
    pending_reqs.push_back(mk_req(FN_MOVE, 32'h0, 3'd7, 32'd0, 9'd3, 9'd0));
    pending_reqs.push_back(mk_req(FN_MOVE, 32'h0, 3'd2, 32'd1, 9'd300, 9'd0));
    pending_reqs.push_back(mk_req(FN_SPARE_A, 32'hFFFF_FFFF, 3'd7, 32'd1, 9'd1, 9'd1));
    pending_reqs.push_back(mk_req(FN_SPARE_B, 32'h0, 3'd0, 32'd0, 9'd511, 9'd511));
    pending_reqs.push_back(mk_req(FN_ADD_SORTED, 32'h8, 3'd0, 32'd5, 9'd0, 9'd0));
    drain();

    // Random phases, each under its own capacity, with and without idling.
    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      no_idle = (p % 4 == 3);
      for (int n = 0; n < 50; n++) pending_reqs.push_back(random_req());
      drain();
    end

    $display("tb: %0d requests taken and %0d results checked over %0d capacity settings",
             reqs_sent, rsps_seen, $size(cap_plan) + 1);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- pooled_sorted_list_manager_core.f -----
hw/rtl/pslm_pkg.sv
hw/rtl/pslm_ram.sv
hw/rtl/pooled_sorted_list_manager_core.sv
dv/testbench.sv
